FILE: rtl/core/cstb_pkg.sv
// ----------------------------------------------------------------------------
// cstb_pkg
// shared types and fixed-point helpers for the cardinal spline to bezier unit
// ----------------------------------------------------------------------------
package cstb_pkg;

  localparam int unsigned CoordW = 16;
  localparam logic [CoordW-1:0] RecipReset = 16'd819;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // what one point transfer leads to
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TAN,
    KIND_ONE,
    KIND_SEG,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    kind_t kind;
    pt_t   older;
    pt_t   recent;
    pt_t   point;
  } hist_t;

  // segment one is pa..pb with tangents ta/tb, segment two is pb..pc with tb/tc
  typedef struct packed {
    logic [1:0] cnt;
    logic       first_last;
    pt_t        pa;
    pt_t        pb;
    pt_t        pc;
    pt_t        ta;
    pt_t        tb;
    pt_t        tc;
  } pend_t;

  function automatic coord_t sat22(logic signed [21:0] v);
    coord_t res;
    if (v > 22'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      res = -16'sh8000;
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

  // (hi - lo) * recip in q4.12, rounded half up, saturated
  function automatic coord_t tangent_of(coord_t hi, coord_t lo, logic [CoordW-1:0] recip);
    logic signed [CoordW:0]     diff;
    logic signed [2*CoordW+1:0] prod;
    diff = {hi[CoordW-1], hi} - {lo[CoordW-1], lo};
    prod = diff * $signed({1'b0, recip});
    prod = prod + 34'sd2048;
    return sat22(prod[2*CoordW+1:12]);
  endfunction

  // point plus or minus tangent, saturated
  function automatic coord_t ctrl_of(coord_t p, coord_t t, logic sub);
    logic signed [CoordW:0] s;
    coord_t res;
    if (sub) begin
      s = {p[CoordW-1], p} - {t[CoordW-1], t};
    end else begin
      s = {p[CoordW-1], p} + {t[CoordW-1], t};
    end
    if (s[CoordW] != s[CoordW-1]) begin
      res = s[CoordW] ? -16'sh8000 : 16'sh7fff;
    end else begin
      res = s[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/cstb_chan_if.sv
// ----------------------------------------------------------------------------
// cstb channel interfaces
// point input channel and bezier segment result channel, valid/ready
// ----------------------------------------------------------------------------
interface cstb_point_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  point_x;
  logic signed [15:0]  point_y;
  logic                final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input final_point,
                output ready);
endinterface

interface cstb_seg_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  start_x;
  logic signed [15:0]  start_y;
  logic signed [15:0]  first_ctrl_x;
  logic signed [15:0]  first_ctrl_y;
  logic signed [15:0]  second_ctrl_x;
  logic signed [15:0]  second_ctrl_y;
  logic signed [15:0]  end_x;
  logic signed [15:0]  end_y;
  logic                last_segment;

  modport source (output valid, output start_x, output start_y, output first_ctrl_x,
                  output first_ctrl_y, output second_ctrl_x, output second_ctrl_y,
                  output end_x, output end_y, output last_segment, input ready);
  modport sink (input valid, input start_x, input start_y, input first_ctrl_x,
                input first_ctrl_y, input second_ctrl_x, input second_ctrl_y,
                input end_x, input end_y, input last_segment, output ready);
endinterface

FILE: rtl/core/cstb_hist.sv
// ----------------------------------------------------------------------------
// cstb_hist
// point history tracker and input register stage
// ----------------------------------------------------------------------------
module cstb_hist (
  input  logic           clk,
  input  logic           rst_n,
  cstb_point_if.sink     in_pt,
  output cstb_pkg::hist_t s1_data,
  output logic           s1_valid,
  input  logic           s1_ready
);
  import cstb_pkg::*;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_TWO
  } seen_t;

  seen_t seen_r;
  pt_t   older_r;
  pt_t   recent_r;
  hist_t s1_r;
  logic  s1_vld_r;
  pt_t   pt_in;
  logic  xfer;

  assign pt_in.x      = in_pt.point_x;
  assign pt_in.y      = in_pt.point_y;
  assign in_pt.ready  = !s1_vld_r || s1_ready;
  assign xfer         = in_pt.valid && in_pt.ready;
  assign s1_data      = s1_r;
  assign s1_valid     = s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= SEEN_NONE;
      older_r  <= '0;
      recent_r <= '0;
      s1_vld_r <= 1'b0;
      s1_r     <= '0;
    end else begin
      if (xfer) begin
        s1_vld_r <= 1'b1;
      end else if (s1_ready) begin
        s1_vld_r <= 1'b0;
      end
      if (xfer) begin
        s1_r.older    <= older_r;
        s1_r.recent   <= recent_r;
        s1_r.point    <= pt_in;
        unique case (seen_r)
          SEEN_NONE: begin
            s1_r.kind <= KIND_NONE;
            recent_r  <= pt_in;
            seen_r    <= in_pt.final_point ? SEEN_NONE : SEEN_ONE;
          end
          SEEN_ONE: begin
            if (in_pt.final_point) begin
              s1_r.kind <= KIND_ONE;
              seen_r    <= SEEN_NONE;
            end else begin
              s1_r.kind <= KIND_TAN;
              older_r   <= recent_r;
              recent_r  <= pt_in;
              seen_r    <= SEEN_TWO;
            end
          end
          SEEN_TWO: begin
            if (in_pt.final_point) begin
              s1_r.kind <= KIND_TWO;
              seen_r    <= SEEN_NONE;
            end else begin
              s1_r.kind <= KIND_SEG;
              older_r   <= recent_r;
              recent_r  <= pt_in;
            end
          end
          default: begin
            s1_r.kind <= KIND_NONE;
            seen_r    <= SEEN_NONE;
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/cstb_tan.sv
// ----------------------------------------------------------------------------
// cstb_tan
// tangent multipliers, held tangent and pending segment register
// ----------------------------------------------------------------------------
module cstb_tan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  input  cstb_pkg::hist_t          s1_data,
  input  logic                     s1_valid,
  output logic                     s1_ready,
  output cstb_pkg::pend_t          pend_data,
  output logic                     pend_valid,
  input  logic                     pend_ready
);
  import cstb_pkg::*;

  logic [CoordW-1:0] recip_r;
  pt_t               tan_r;
  pend_t             pend_r;
  pend_t             pend_nxt;
  logic              pend_vld_r;
  pt_t               m1;
  pt_t               m2;
  logic              has_res;
  logic              mv;

  // m1 spans older to new point, m2 spans recent to new point
  assign m1.x = tangent_of(s1_data.point.x, s1_data.older.x, recip_r);
  assign m1.y = tangent_of(s1_data.point.y, s1_data.older.y, recip_r);
  assign m2.x = tangent_of(s1_data.point.x, s1_data.recent.x, recip_r);
  assign m2.y = tangent_of(s1_data.point.y, s1_data.recent.y, recip_r);

  assign has_res    = (s1_data.kind == KIND_ONE) || (s1_data.kind == KIND_SEG) ||
                      (s1_data.kind == KIND_TWO);
  assign s1_ready   = !has_res || !pend_vld_r || pend_ready;
  assign mv         = s1_valid && s1_ready;
  assign pend_data  = pend_r;
  assign pend_valid = pend_vld_r;

  always_comb begin
    pend_nxt.pc = s1_data.point;
    pend_nxt.tc = m2;
    unique case (s1_data.kind)
      KIND_ONE: begin
        pend_nxt.cnt        = 2'd1;
        pend_nxt.first_last = 1'b1;
        pend_nxt.pa         = s1_data.recent;
        pend_nxt.ta         = m2;
        pend_nxt.pb         = s1_data.point;
        pend_nxt.tb         = m2;
      end
      KIND_SEG, KIND_TWO: begin
        pend_nxt.cnt        = (s1_data.kind == KIND_TWO) ? 2'd2 : 2'd1;
        pend_nxt.first_last = 1'b0;
        pend_nxt.pa         = s1_data.older;
        pend_nxt.ta         = tan_r;
        pend_nxt.pb         = s1_data.recent;
        pend_nxt.tb         = m1;
      end
      default: begin
        pend_nxt.cnt        = 2'd0;
        pend_nxt.first_last = 1'b0;
        pend_nxt.pa         = s1_data.older;
        pend_nxt.ta         = tan_r;
        pend_nxt.pb         = s1_data.recent;
        pend_nxt.tb         = m1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r    <= RecipReset;
      tan_r      <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        recip_r <= cfg_wdata;
      end
      if (mv && has_res) begin
        pend_vld_r <= 1'b1;
      end else if (pend_ready) begin
        pend_vld_r <= 1'b0;
      end
      if (mv && s1_data.kind == KIND_TAN) begin
        tan_r <= m2;
      end else if (mv && s1_data.kind == KIND_SEG) begin
        tan_r <= m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv && has_res) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: rtl/core/cstb_emit.sv
// ----------------------------------------------------------------------------
// cstb_emit
// control point adders and result register, one or two results per pending item
// ----------------------------------------------------------------------------
module cstb_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  cstb_pkg::pend_t pend_data,
  input  logic            pend_valid,
  output logic            pend_ready,
  cstb_seg_if.source      out_seg
);
  import cstb_pkg::*;

  logic phase_r;
  logic out_vld_r;
  pt_t  start_r;
  pt_t  c1_r;
  pt_t  c2_r;
  pt_t  end_r;
  logic last_r;
  logic load;
  logic done_item;
  pt_t  s_pt;
  pt_t  s_tan;
  pt_t  e_pt;
  pt_t  e_tan;
  logic s_last;

  assign load       = pend_valid && (!out_vld_r || out_seg.ready);
  assign done_item  = (pend_data.cnt != 2'd2) || phase_r;
  assign pend_ready = load && done_item;

  always_comb begin
    if (phase_r) begin
      s_pt   = pend_data.pb;
      s_tan  = pend_data.tb;
      e_pt   = pend_data.pc;
      e_tan  = pend_data.tc;
      s_last = 1'b1;
    end else begin
      s_pt   = pend_data.pa;
      s_tan  = pend_data.ta;
      e_pt   = pend_data.pb;
      e_tan  = pend_data.tb;
      s_last = pend_data.first_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        phase_r   <= !done_item;
      end else if (out_seg.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= s_pt;
      c1_r.x  <= ctrl_of(s_pt.x, s_tan.x, 1'b0);
      c1_r.y  <= ctrl_of(s_pt.y, s_tan.y, 1'b0);
      c2_r.x  <= ctrl_of(e_pt.x, e_tan.x, 1'b1);
      c2_r.y  <= ctrl_of(e_pt.y, e_tan.y, 1'b1);
      end_r   <= e_pt;
      last_r  <= s_last;
    end
  end

  assign out_seg.valid         = out_vld_r;
  assign out_seg.start_x       = start_r.x;
  assign out_seg.start_y       = start_r.y;
  assign out_seg.first_ctrl_x  = c1_r.x;
  assign out_seg.first_ctrl_y  = c1_r.y;
  assign out_seg.second_ctrl_x = c2_r.x;
  assign out_seg.second_ctrl_y = c2_r.y;
  assign out_seg.end_x         = end_r.x;
  assign out_seg.end_y         = end_r.y;
  assign out_seg.last_segment  = last_r;

`ifndef SYNTHESIS
  a_phase_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (pend_valid && pend_data.cnt == 2'd2))
    else $error("second segment phase without a two segment item");

  a_pend_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid |-> (pend_data.cnt != 2'd0))
    else $error("pending item with no segment");

  a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r) |=> (out_vld_r && last_r))
    else $error("closing segment not marked last");

  a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !phase_r && pend_data.cnt == 2'd2) |=> (out_vld_r && !last_r && phase_r))
    else $error("first of two segments marked last or phase lost");
`endif

endmodule

FILE: rtl/core/cardinal_spline_to_bezier_unit.sv
// ----------------------------------------------------------------------------
// cardinal_spline_to_bezier_unit
// converts a polyline point stream into cubic bezier segments
// ----------------------------------------------------------------------------
// Points (signed q12.4) enter one per cycle while the result side is ready;
// the first segment a point completes passes the input register, the pending
// segment register and the result register, and a second one follows from the
// same result register. The tangent at an inner point is the difference of its
// neighbors times the tension reciprocal from cfg_wdata (unsigned q4.12), at
// the ends the difference with the one neighbor; control values saturate to 16
// bits. A final point that closes a polyline of three or more points gives two
// segments in turn from the single result register; the first point of the next
// polyline gives no segment, so the second segment never holds the input.
// A final point with no point before it gives nothing.
// Write cfg_wdata with cfg_we only while no point is in flight.
module cardinal_spline_to_bezier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cstb_point_if.sink  in_pt,
  cstb_seg_if.source  out_seg
);
  import cstb_pkg::*;

  hist_t s1_data;
  logic  s1_valid;
  logic  s1_ready;
  pend_t pend_data;
  logic  pend_valid;
  logic  pend_ready;

  cstb_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (in_pt),
    .s1_data  (s1_data),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready)
  );

  cstb_tan u_tan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s1_data    (s1_data),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .pend_data  (pend_data),
    .pend_valid (pend_valid),
    .pend_ready (pend_ready)
  );

  cstb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_data  (pend_data),
    .pend_valid (pend_valid),
    .pend_ready (pend_ready),
    .out_seg    (out_seg)
  );

endmodule

FILE: test/cardinal_spline_to_bezier_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cardinal_spline_to_bezier_unit_tb
// Feeds polylines of random and hand-picked points through the spline unit
// and predicts every bezier segment from the point stream and the tension
// reciprocal. Results are compared field by field in transfer order, under
// random idling on both channels, a long result hold-off and several
// tension settings from zero to full scale.
// ----------------------------------------------------------------------------
module cardinal_spline_to_bezier_unit_tb;
  import cstb_pkg::*;

  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned SettleCycles   = 8;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
    coord_t ex;
    coord_t ey;
    logic   last;
  } seg_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  cstb_point_if pt_if ();
  cstb_seg_if   seg_if ();

  cardinal_spline_to_bezier_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_pt    (pt_if),
    .out_seg  (seg_if)
  );

  // spline state mirrored from the point stream
  logic [15:0] recip_q412;
  pt_t         prev_pt;
  pt_t         last_pt;
  pt_t         held_tan;
  int          held_count;
  seg_t        seg_expected[$];

  int          err_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic coord_t clamp16(longint v);
    if (v > 32767) return coord_t'(16'h7fff);
    if (v < -32768) return coord_t'(16'h8000);
    return coord_t'(v);
  endfunction

  // (hi - lo) * recip, q4.12 rounded half up
  function automatic coord_t tangent_q(coord_t hi, coord_t lo);
    longint v;
    v = (longint'(hi) - longint'(lo)) * longint'(recip_q412) + 2048;
    return clamp16(v >>> 12);
  endfunction

  function automatic pt_t tangent_pair(pt_t hi, pt_t lo);
    pt_t t;
    t.x = tangent_q(hi.x, lo.x);
    t.y = tangent_q(hi.y, lo.y);
    return t;
  endfunction

  function automatic seg_t bezier_of(pt_t a, pt_t ta, pt_t b, pt_t tb, logic last);
    seg_t s;
    s.sx   = a.x;
    s.sy   = a.y;
    s.c1x  = clamp16(longint'(a.x) + longint'(ta.x));
    s.c1y  = clamp16(longint'(a.y) + longint'(ta.y));
    s.c2x  = clamp16(longint'(b.x) - longint'(tb.x));
    s.c2y  = clamp16(longint'(b.y) - longint'(tb.y));
    s.ex   = b.x;
    s.ey   = b.y;
    s.last = last;
    return s;
  endfunction

  task automatic predict_point(input pt_t p, input logic fin);
    pt_t tb;
    pt_t tc;
    case (held_count)
      0: begin
        last_pt    = p;
        held_count = fin ? 0 : 1;
      end
      1: begin
        tb = tangent_pair(p, last_pt);
        if (fin) begin
          seg_expected.push_back(bezier_of(last_pt, tb, p, tb, 1'b1));
          held_count = 0;
        end else begin
          prev_pt    = last_pt;
          last_pt    = p;
          held_tan   = tb;
          held_count = 2;
        end
      end
      default: begin
        tb = tangent_pair(p, prev_pt);
        seg_expected.push_back(bezier_of(prev_pt, held_tan, last_pt, tb, 1'b0));
        if (fin) begin
          tc = tangent_pair(p, last_pt);
          seg_expected.push_back(bezier_of(last_pt, tb, p, tc, 1'b1));
          held_count = 0;
        end else begin
          prev_pt  = last_pt;
          last_pt  = p;
          held_tan = tb;
        end
      end
    endcase
  endtask

  function automatic coord_t rand_coord(coord_t near);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return coord_t'(16'h7fff);
          1: return coord_t'(16'h8000);
          2: return coord_t'(16'h0000);
          default: return coord_t'(16'hffff);
        endcase
      end
      1, 2, 3: return coord_t'($urandom());
      default: return coord_t'(int'(near) + int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic send_point(input pt_t p, input logic fin);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid       <= 1'b1;
    pt_if.point_x     <= p.x;
    pt_if.point_y     <= p.y;
    pt_if.final_point <= fin;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    predict_point(p, fin);
  endtask

  task automatic send_xy(input int x, input int y, input logic fin);
    pt_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    send_point(p, fin);
  endtask

  task automatic drain_results();
    pt_if.valid <= 1'b0;
    while (seg_expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_recip(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    recip_q412 = value;
  endtask

  task automatic run_polylines(input int n_items, input bit idle_mix);
    int  left;
    int  len;
    pt_t p;
    p.x  = '0;
    p.y  = '0;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
      if (len > left) len = left;
      if (idle_mix) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < len; k++) begin
        p.x = rand_coord(p.x);
        p.y = rand_coord(p.y);
        send_point(p, k == len - 1);
      end
      left -= len;
      if ($urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // lone point
    send_xy(100, -50, 1'b1);
    // two points
    send_xy(0, 0, 1'b0);
    send_xy(16, -16, 1'b1);
    // control values pushed past full scale
    send_xy(0, 0, 1'b0);
    send_xy(32000, -32000, 1'b0);
    send_xy(32767, -32768, 1'b1);
    // coordinate extremes
    send_xy(-32768, 32767, 1'b0);
    send_xy(32767, -32768, 1'b0);
    send_xy(-32768, 32767, 1'b1);
    // pending segment then closing segment
    send_xy(10, 20, 1'b0);
    send_xy(300, -400, 1'b0);
    send_xy(-700, 800, 1'b0);
    send_xy(50, 60, 1'b1);
    drain_results();
    // full-scale reciprocal saturates the tangent
    write_recip(16'hffff);
    send_xy(-32768, -32768, 1'b0);
    send_xy(32767, 32767, 1'b1);
    send_xy(32767, 0, 1'b0);
    send_xy(0, 0, 1'b0);
    send_xy(-32768, 0, 1'b1);
    drain_results();
    // zero reciprocal gives flat controls
    write_recip(16'h0000);
    send_xy(1, 2, 1'b0);
    send_xy(3, 4, 1'b0);
    send_xy(5, 6, 1'b1);
    drain_results();
    write_recip(RecipReset);
  endtask

  task automatic test_tension_sweep();
    logic [15:0] settings[6];
    settings[0] = 16'h0000;
    settings[1] = 16'hffff;
    settings[2] = 16'h0001;
    settings[3] = 16'h1000;
    settings[4] = 16'($urandom());
    settings[5] = RecipReset;
    foreach (settings[i]) begin
      drain_results();
      write_recip(settings[i]);
      run_polylines(110, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = LongHoldCycles;
    run_polylines(80, 1'b0);
    drain_results();
  endtask

  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_polylines(190, 1'b0);
  endtask

  // result side ready with random stalls and the long hold-off
  initial begin : seg_sink
    int n;
    seg_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        seg_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        seg_if.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        seg_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        seg_if.ready <= 1'b1;
      end else begin
        seg_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // one comparison per result transfer
  always @(posedge clk) begin : seg_check
    seg_t got;
    seg_t want;
    if (rst_n && seg_if.valid && seg_if.ready) begin
      got.sx   = seg_if.start_x;
      got.sy   = seg_if.start_y;
      got.c1x  = seg_if.first_ctrl_x;
      got.c1y  = seg_if.first_ctrl_y;
      got.c2x  = seg_if.second_ctrl_x;
      got.c2y  = seg_if.second_ctrl_y;
      got.ex   = seg_if.end_x;
      got.ey   = seg_if.end_y;
      got.last = seg_if.last_segment;
      if (seg_expected.size() == 0) begin
        err_count++;
        $display("%0t: unexpected segment expected none actual %h", $time, got);
      end else begin
        want = seg_expected.pop_front();
        check_field("start_x", want.sx, got.sx);
        check_field("start_y", want.sy, got.sy);
        check_field("first_ctrl_x", want.c1x, got.c1x);
        check_field("first_ctrl_y", want.c1y, got.c1y);
        check_field("second_ctrl_x", want.c2x, got.c2x);
        check_field("second_ctrl_y", want.c2y, got.c2y);
        check_field("end_x", want.ex, got.ex);
        check_field("end_y", want.ey, got.ey);
        check_field("last_segment", want.last, got.last);
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    pt_if.valid       <= 1'b0;
    pt_if.point_x     <= '0;
    pt_if.point_y     <= '0;
    pt_if.final_point <= 1'b0;
    err_count      = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 0;
    recip_q412     = RecipReset;
    prev_pt        = '0;
    last_pt        = '0;
    held_tan       = '0;
    held_count     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_tension_sweep();
    test_backpressure();
    test_full_rate();

    pt_if.valid <= 1'b0;
    while (seg_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
